>>> rtl/cmcls_pkg.sv
package cmcls_pkg;

	localparam int MAX_VERTICES = 128;
	localparam int WEIGHT_BITS = 16;

	localparam int VIDX_W = $clog2(MAX_VERTICES);
	localparam int CNT_W = $clog2(MAX_VERTICES + 1);
	localparam int PASS_W = $clog2(MAX_VERTICES + 2);
	localparam int ADDR_W = 2 * VIDX_W;
	localparam int CUT_W = WEIGHT_BITS + 2 * VIDX_W;
	localparam int DIFF_W = WEIGHT_BITS + VIDX_W + 1;
	localparam int VC_RESET = (MAX_VERTICES < 128) ? MAX_VERTICES : 128;

	localparam logic [1:0] KIND_EDGE = 2'd0;
	localparam logic [1:0] KIND_SIDE = 2'd1;
	localparam logic [1:0] KIND_RUN = 2'd2;
	localparam logic [1:0] KIND_QUERY = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDGE2,
		ST_CUT_ROW,
		ST_DEG_ROW,
		ST_MOV_ROW,
		ST_TRY_SEL,
		ST_TRY_ROW,
		ST_TRY_CMP,
		ST_SEEK,
		ST_POP,
		ST_POP_WAIT,
		ST_WALK_ROW,
		ST_CONN_END,
		ST_APPLY
	} state_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] addr;
		logic [WEIGHT_BITS-1:0] wdata;
	} edge_req_t;

	function automatic logic [29:0] clamp30(input logic [CUT_W-1:0] c);
		logic [63:0] c64;
		c64 = 64'(c);
		return (c64 > 64'd1073741823) ? 30'h3FFF_FFFF : c64[29:0];
	endfunction

	function automatic logic [7:0] sat8(input logic [PASS_W-1:0] p);
		logic [31:0] p32;
		p32 = 32'(p);
		return (p32 > 32'd255) ? 8'hFF : p32[7:0];
	endfunction

endpackage

>>> rtl/connected_max_cut_local_search.sv
// Channel   Direction  Handshake              Payload
// request   in         start, busy            kind, vertex_a, vertex_b, weight, side
// result    out        done (one-cycle pulse) final_cut, best_cut, passes_done,
//                                             stopped_early, vertex_side
// config    in         cfg_valid, cfg_ready   cfg_data (vertex count)
//
// Side loads write the side bit on acceptance; edge loads write both mirrored entries in
// ST_IDLE and then ST_EDGE2 (one RAM port); a query answers the next cycle. A run scans the
// n rows once for the cut, then each pass scans every row twice (degree, movable), scans one
// row per movable vertex, and per improving trial seeks the seeds and walks one row per reached vertex.
// After reset the edge RAM sweeps every entry to zero; busy is high meanwhile.
// The result is shown for one cycle only; the receiver cannot stall.
module connected_max_cut_local_search (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] kind,
	input  logic [7:0] vertex_a,
	input  logic [7:0] vertex_b,
	input  logic [15:0] weight,
	input  logic side,
	output logic done,
	output logic [29:0] final_cut,
	output logic [29:0] best_cut,
	output logic [7:0] passes_done,
	output logic stopped_early,
	output logic vertex_side,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int MV = cmcls_pkg::MAX_VERTICES;
	localparam int VW = cmcls_pkg::VIDX_W;
	localparam int CW = cmcls_pkg::CNT_W;
	localparam int PW = cmcls_pkg::PASS_W;
	localparam int WB = cmcls_pkg::WEIGHT_BITS;
	localparam int UW = cmcls_pkg::CUT_W;
	localparam int DW = cmcls_pkg::DIFF_W;

	cmcls_pkg::state_t state_q, state_d;
	cmcls_pkg::edge_req_t req;

	logic [CW-1:0] vcount_q;
	logic [MV-1:0] side_q;
	logic [MV-1:0] other_ok_q, movable_q, mark_q;
	logic [VW-1:0] row_q, col_s1, pick_q, first0_q, first1_q;
	logic [CW-1:0] col_q, same_cnt_q, oth_cnt_q, sp_q, mark_cnt_q, v_q, idx_q;
	logic valid_s1, bad_q, found_q, have0_q, have1_q, phase_q, done_q;
	logic [UW-1:0] cut_q, best_q, pick_cut_q, trial_q;
	logic signed [DW-1:0] diff_q;
	logic signed [UW:0] tsum;
	logic [PW-1:0] pass_q;
	logic [cmcls_pkg::ADDR_W-1:0] pend_addr_q;
	logic [WB-1:0] pend_w_q, w_in, w_rd;
	logic [VW-1:0] same_mem [MV];
	logic [VW-1:0] stack_mem [MV];
	logic [VW-1:0] same_rd_q, stack_rd_q;
	logic [29:0] final_cut_q, best_cut_q;
	logic [7:0] passes_q;
	logic early_q, vside_q;

	logic ram_ready, accept, a_ok, b_ok, edge_ok;
	logic [VW-1:0] ai, bi, vi;
	logic scan_state, scan_issue, scan_end, row_last, w_nz, sy, srow;
	logic finish_early, finish_last, conn_ok;
	logic [31:0] cv32, cvc;

	cmcls_edge_ram u_ram (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rdata(w_rd),
		.ready(ram_ready)
	);

	assign cfg_ready = 1'b1;
	assign done = done_q;
	assign final_cut = final_cut_q;
	assign best_cut = best_cut_q;
	assign passes_done = passes_q;
	assign stopped_early = early_q;
	assign vertex_side = vside_q;

	assign accept = start && !busy;
	assign a_ok = (vertex_a != 8'd0) && (32'(vertex_a) <= 32'(MV));
	assign b_ok = (vertex_b != 8'd0) && (32'(vertex_b) <= 32'(MV));
	assign edge_ok = a_ok && b_ok && (vertex_a != vertex_b);
	assign ai = VW'(vertex_a - 8'd1);
	assign bi = VW'(vertex_b - 8'd1);
	assign vi = v_q[VW-1:0];
	assign w_in = WB'(weight);
	assign w_nz = |w_rd;
	assign sy = side_q[col_s1];
	assign srow = side_q[row_q];
	assign row_last = (CW'(row_q) + CW'(1)) == vcount_q;
	assign tsum = $signed({1'b0, cut_q}) + (UW + 1)'(diff_q);
	assign finish_early = (state_q == cmcls_pkg::ST_TRY_SEL) && (v_q == vcount_q) && !found_q;
	assign finish_last = (state_q == cmcls_pkg::ST_APPLY) && (pass_q == PW'(vcount_q));
	assign conn_ok = have0_q && have1_q && (mark_cnt_q == vcount_q);
	assign cv32 = 32'(cfg_data);
	assign cvc = (cv32 < 32'd2) ? 32'd2 : ((cv32 > 32'(MV)) ? 32'(MV) : cv32);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cmcls_pkg::ST_IDLE: begin
				if (accept && kind == cmcls_pkg::KIND_RUN) state_d = cmcls_pkg::ST_CUT_ROW;
				else if (accept && kind == cmcls_pkg::KIND_EDGE && edge_ok)
					state_d = cmcls_pkg::ST_EDGE2;
			end
			cmcls_pkg::ST_EDGE2: state_d = cmcls_pkg::ST_IDLE;
			cmcls_pkg::ST_CUT_ROW: if (scan_end && row_last) state_d = cmcls_pkg::ST_DEG_ROW;
			cmcls_pkg::ST_DEG_ROW: if (scan_end && row_last) state_d = cmcls_pkg::ST_MOV_ROW;
			cmcls_pkg::ST_MOV_ROW: if (scan_end && row_last) state_d = cmcls_pkg::ST_TRY_SEL;
			cmcls_pkg::ST_TRY_SEL: begin
				if (v_q == vcount_q) begin
					state_d = found_q ? cmcls_pkg::ST_APPLY : cmcls_pkg::ST_IDLE;
				end else if (movable_q[vi]) begin
					state_d = cmcls_pkg::ST_TRY_ROW;
				end
			end
			cmcls_pkg::ST_TRY_ROW: if (scan_end) state_d = cmcls_pkg::ST_TRY_CMP;
			cmcls_pkg::ST_TRY_CMP: begin
				state_d = (trial_q > pick_cut_q) ? cmcls_pkg::ST_SEEK : cmcls_pkg::ST_TRY_SEL;
			end
			cmcls_pkg::ST_SEEK: begin
				if (idx_q == vcount_q)
					state_d = (have0_q && have1_q) ? cmcls_pkg::ST_POP : cmcls_pkg::ST_CONN_END;
			end
			cmcls_pkg::ST_POP: begin
				if (sp_q != '0) state_d = cmcls_pkg::ST_POP_WAIT;
				else if (phase_q) state_d = cmcls_pkg::ST_CONN_END;
			end
			cmcls_pkg::ST_POP_WAIT: state_d = cmcls_pkg::ST_WALK_ROW;
			cmcls_pkg::ST_WALK_ROW: if (scan_end) state_d = cmcls_pkg::ST_POP;
			cmcls_pkg::ST_CONN_END: state_d = cmcls_pkg::ST_TRY_SEL;
			cmcls_pkg::ST_APPLY: state_d = finish_last ? cmcls_pkg::ST_IDLE : cmcls_pkg::ST_DEG_ROW;
			default: state_d = cmcls_pkg::ST_IDLE;
		endcase
	end

	// control outputs and RAM port
	always_comb begin
		busy = (state_q != cmcls_pkg::ST_IDLE) || !ram_ready;
		scan_state = (state_q == cmcls_pkg::ST_CUT_ROW) || (state_q == cmcls_pkg::ST_DEG_ROW) ||
			(state_q == cmcls_pkg::ST_MOV_ROW) || (state_q == cmcls_pkg::ST_TRY_ROW) ||
			(state_q == cmcls_pkg::ST_WALK_ROW);
		scan_issue = scan_state && (col_q < vcount_q);
		scan_end = scan_state && (col_q == vcount_q) && !valid_s1;
		req.we = 1'b0;
		req.addr = {row_q, col_q[VW-1:0]};
		req.wdata = '0;
		case (state_q)
			cmcls_pkg::ST_IDLE: begin
				if (accept && kind == cmcls_pkg::KIND_EDGE && edge_ok) begin
					req.we = 1'b1;
					req.addr = {ai, bi};
					req.wdata = w_in;
				end
			end
			cmcls_pkg::ST_EDGE2: begin
				req.we = 1'b1;
				req.addr = pend_addr_q;
				req.wdata = pend_w_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmcls_pkg::ST_IDLE;
			vcount_q <= CW'(cmcls_pkg::VC_RESET);
			side_q <= '0;
			col_q <= '0;
			valid_s1 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) vcount_q <= CW'(cvc);
			valid_s1 <= scan_issue;
			if (scan_issue) col_q <= col_q + 1'b1;
			else if (scan_end || !scan_state) col_q <= '0;
			done_q <= (accept && kind == cmcls_pkg::KIND_QUERY) || finish_early || finish_last;
			if (state_q == cmcls_pkg::ST_IDLE && accept && kind == cmcls_pkg::KIND_SIDE && a_ok)
				side_q[ai] <= side;
			// flip the trial vertex for the walk, restore it afterwards
			if (state_q == cmcls_pkg::ST_TRY_CMP && trial_q > pick_cut_q) side_q[vi] <= !side_q[vi];
			if (state_q == cmcls_pkg::ST_CONN_END) side_q[vi] <= !side_q[vi];
			if (state_q == cmcls_pkg::ST_APPLY) side_q[pick_q] <= !side_q[pick_q];
		end
	end

	always_ff @(posedge clk) begin
		col_s1 <= col_q[VW-1:0];
		same_rd_q <= same_mem[col_q[VW-1:0]];
		case (state_q)
			cmcls_pkg::ST_IDLE: begin
				pend_addr_q <= {bi, ai};
				pend_w_q <= w_in;
				cut_q <= '0;
				row_q <= '0;
				pass_q <= '0;
				same_cnt_q <= '0;
				oth_cnt_q <= '0;
				bad_q <= 1'b0;
				diff_q <= '0;
				if (accept && kind == cmcls_pkg::KIND_QUERY) begin
					final_cut_q <= '0;
					best_cut_q <= '0;
					passes_q <= '0;
					early_q <= 1'b0;
					vside_q <= a_ok ? side_q[ai] : 1'b0;
				end
			end
			cmcls_pkg::ST_CUT_ROW: begin
				if (valid_s1 && col_s1 > row_q && sy != srow) cut_q <= cut_q + UW'(w_rd);
				if (scan_end) begin
					row_q <= row_last ? '0 : row_q + 1'b1;
					best_q <= cut_q;
				end
			end
			cmcls_pkg::ST_DEG_ROW: begin
				if (valid_s1 && w_nz) begin
					if (sy == srow) same_cnt_q <= same_cnt_q + 1'b1;
					else oth_cnt_q <= oth_cnt_q + 1'b1;
				end
				if (scan_end) begin
					same_mem[row_q] <= same_cnt_q[VW-1:0];
					other_ok_q[row_q] <= oth_cnt_q >= CW'(2);
					same_cnt_q <= '0;
					oth_cnt_q <= '0;
					row_q <= row_last ? '0 : row_q + 1'b1;
				end
			end
			cmcls_pkg::ST_MOV_ROW: begin
				// drop the vertex if a same-side neighbor has two or fewer same-side neighbors
				if (valid_s1 && w_nz && sy == srow && same_rd_q <= VW'(2)) bad_q <= 1'b1;
				if (scan_end) begin
					movable_q[row_q] <= other_ok_q[row_q] && !bad_q;
					bad_q <= 1'b0;
					row_q <= row_last ? '0 : row_q + 1'b1;
				end
				v_q <= '0;
				found_q <= 1'b0;
				pick_cut_q <= '0;
			end
			cmcls_pkg::ST_TRY_SEL: begin
				if (v_q == vcount_q) begin
					if (!found_q) begin
						final_cut_q <= cmcls_pkg::clamp30(cut_q);
						best_cut_q <= cmcls_pkg::clamp30(best_q);
						passes_q <= cmcls_pkg::sat8(pass_q);
						early_q <= 1'b1;
						vside_q <= 1'b0;
					end
				end else if (movable_q[vi]) begin
					row_q <= vi;
				end else begin
					v_q <= v_q + 1'b1;
				end
			end
			cmcls_pkg::ST_TRY_ROW: begin
				if (valid_s1) begin
					if (sy == srow) diff_q <= diff_q + $signed(DW'(w_rd));
					else diff_q <= diff_q - $signed(DW'(w_rd));
				end
				if (scan_end) begin
					trial_q <= tsum[UW-1:0];
					diff_q <= '0;
				end
			end
			cmcls_pkg::ST_TRY_CMP: begin
				if (trial_q > pick_cut_q) begin
					mark_q <= '0;
					mark_cnt_q <= '0;
					sp_q <= '0;
					have0_q <= 1'b0;
					have1_q <= 1'b0;
					idx_q <= '0;
				end else begin
					v_q <= v_q + 1'b1;
				end
			end
			cmcls_pkg::ST_SEEK: begin
				if (idx_q != vcount_q) begin
					if (!side_q[idx_q[VW-1:0]] && !have0_q) begin
						first0_q <= idx_q[VW-1:0];
						have0_q <= 1'b1;
					end
					if (side_q[idx_q[VW-1:0]] && !have1_q) begin
						first1_q <= idx_q[VW-1:0];
						have1_q <= 1'b1;
					end
					idx_q <= idx_q + 1'b1;
				end else if (have0_q && have1_q) begin
					mark_q[first0_q] <= 1'b1;
					stack_mem[0] <= first0_q;
					sp_q <= CW'(1);
					mark_cnt_q <= CW'(1);
					phase_q <= 1'b0;
				end
			end
			cmcls_pkg::ST_POP: begin
				if (sp_q != '0) begin
					stack_rd_q <= stack_mem[VW'(sp_q - 1'b1)];
					sp_q <= sp_q - 1'b1;
				end else if (!phase_q) begin
					// seed the second side
					mark_q[first1_q] <= 1'b1;
					stack_mem[0] <= first1_q;
					sp_q <= CW'(1);
					mark_cnt_q <= mark_cnt_q + 1'b1;
					phase_q <= 1'b1;
				end
			end
			cmcls_pkg::ST_POP_WAIT: row_q <= stack_rd_q;
			cmcls_pkg::ST_WALK_ROW: begin
				if (valid_s1 && w_nz && sy == phase_q && !mark_q[col_s1]) begin
					mark_q[col_s1] <= 1'b1;
					stack_mem[sp_q[VW-1:0]] <= col_s1;
					sp_q <= sp_q + 1'b1;
					mark_cnt_q <= mark_cnt_q + 1'b1;
				end
			end
			cmcls_pkg::ST_CONN_END: begin
				if (conn_ok) begin
					found_q <= 1'b1;
					pick_q <= vi;
					pick_cut_q <= trial_q;
				end
				v_q <= v_q + 1'b1;
			end
			cmcls_pkg::ST_APPLY: begin
				cut_q <= pick_cut_q;
				if (pick_cut_q > best_q) best_q <= pick_cut_q;
				pass_q <= pass_q + 1'b1;
				row_q <= '0;
				if (finish_last) begin
					final_cut_q <= cmcls_pkg::clamp30(pick_cut_q);
					best_cut_q <= cmcls_pkg::clamp30((pick_cut_q > best_q) ? pick_cut_q : best_q);
					passes_q <= cmcls_pkg::sat8(pass_q + 1'b1);
					early_q <= 1'b0;
					vside_q <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmcls_pkg::ST_POP) |-> (sp_q <= vcount_q))
		else $error("walk stack beyond vertex count");
	a_mark_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmcls_pkg::ST_CONN_END) |-> (mark_cnt_q <= vcount_q))
		else $error("walk marked more vertices than in use");
	a_apply_found: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cmcls_pkg::ST_APPLY) |-> found_q) else $error("apply without a pick");
	a_no_write_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_issue |-> !req.we) else $error("edge write during a row scan");
	a_no_done_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!ram_ready |=> !done) else $error("result while edge memory clears");

endmodule

>>> rtl/cmcls_edge_ram.sv
module cmcls_edge_ram (
	input  logic clk,
	input  logic arst_n,
	input  cmcls_pkg::edge_req_t req,
	output logic [cmcls_pkg::WEIGHT_BITS-1:0] rdata,
	output logic ready
);

	logic [cmcls_pkg::WEIGHT_BITS-1:0] mem [(1 << cmcls_pkg::ADDR_W)];
	logic [cmcls_pkg::ADDR_W:0] clr_q;
	logic [cmcls_pkg::WEIGHT_BITS-1:0] rd_q;

	assign ready = clr_q[cmcls_pkg::ADDR_W];
	assign rdata = rd_q;

	// sweep every entry to zero once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!ready) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!ready) begin
			mem[clr_q[cmcls_pkg::ADDR_W-1:0]] <= '0;
		end else if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rd_q <= mem[req.addr];
	end

endmodule

>>> tb/sv/connected_max_cut_local_search_test.sv
`timescale 1ns / 1ps

module connected_max_cut_local_search_test;

	localparam int NV = cmcls_pkg::MAX_VERTICES;
	localparam int CYCLE_LIMIT = 20000000;

	typedef struct {
		logic [29:0] final_cut;
		logic [29:0] best_cut;
		logic [7:0] passes_done;
		logic stopped_early;
		logic vertex_side;
	} answer_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [1:0] kind = cmcls_pkg::KIND_EDGE;
	logic [7:0] vertex_a = 0;
	logic [7:0] vertex_b = 0;
	logic [15:0] weight = 0;
	logic side = 0;
	logic done;
	logic [29:0] final_cut;
	logic [29:0] best_cut;
	logic [7:0] passes_done;
	logic stopped_early;
	logic vertex_side;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [7:0] cfg_data = 0;

	connected_max_cut_local_search dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.kind(kind), .vertex_a(vertex_a), .vertex_b(vertex_b), .weight(weight),
		.side(side), .done(done), .final_cut(final_cut), .best_cut(best_cut),
		.passes_done(passes_done), .stopped_early(stopped_early),
		.vertex_side(vertex_side), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// mirror of the graph and split
	logic [15:0] graph_w [0:NV*NV-1];
	bit split [0:NV-1];
	int active_n;
	int same_cnt [0:NV-1];
	int degree [0:NV-1];
	bit can_move [0:NV-1];

	answer_t pending_answers [$];
	int errors = 0;
	int cycles = 0;
	int idle_pct = 0;
	int requests_sent = 0;
	int searches = 0;
	int queries = 0;
	int answers_seen = 0;

	function automatic void queue_answer(answer_t r);
		pending_answers = {pending_answers, r};
	endfunction

	function automatic int wt(int i, int j);
		return graph_w[i*NV + j];
	endfunction

	function automatic longint cut_after_flip(longint c, int v, int n);
		longint same_w, other_w;
		same_w = 0;
		other_w = 0;
		for (int j = 0; j < n; j++) begin
			if (j == v) continue;
			if (split[j] == split[v]) same_w += wt(v, j);
			else other_w += wt(v, j);
		end
		return c + same_w - other_w;
	endfunction

	function automatic void mark_moves(int n);
		for (int i = 0; i < n; i++) begin
			same_cnt[i] = 0;
			degree[i] = 0;
			for (int j = 0; j < n; j++) begin
				if (j == i || wt(i, j) == 0) continue;
				degree[i]++;
				if (split[i] == split[j]) same_cnt[i]++;
			end
		end
		for (int i = 0; i < n; i++) begin
			can_move[i] = (degree[i] - same_cnt[i]) > 1;
			for (int j = 0; j < n; j++) begin
				if (j == i || wt(i, j) == 0) continue;
				if (split[i] == split[j] && same_cnt[j] <= 2) can_move[i] = 0;
			end
		end
	endfunction

	function automatic bit sides_connected(int n);
		int seed [2];
		bit [1:0] reach [0:NV-1];
		int stk [0:NV-1];
		int sp, x, cnt;
		seed[0] = n;
		seed[1] = n;
		for (int i = 0; i < n; i++) begin
			if (split[i] == 0 && seed[0] == n) seed[0] = i;
			if (split[i] == 1 && seed[1] == n) seed[1] = i;
		end
		// an empty side is disconnected
		if (seed[0] == n || seed[1] == n) return 0;
		for (int i = 0; i < n; i++) reach[i] = 0;
		for (int s = 0; s < 2; s++) begin
			reach[seed[s]] = 2'(s + 1);
			stk[0] = seed[s];
			sp = 1;
			while (sp > 0) begin
				sp--;
				x = stk[sp];
				for (int y = 0; y < n; y++) begin
					if (wt(x, y) != 0 && split[y] == split[seed[s]] && reach[y] == 0) begin
						reach[y] = 2'(s + 1);
						stk[sp] = y;
						sp++;
					end
				end
			end
		end
		cnt = 0;
		for (int i = 0; i < n; i++) if (reach[i] != 0) cnt++;
		return cnt == n;
	endfunction

	function automatic logic [29:0] clip30(longint c);
		return (c > 64'd1073741823) ? 30'h3FFF_FFFF : c[29:0];
	endfunction

	function automatic answer_t search_cut();
		answer_t r;
		int n, pick, moves;
		longint cut, best, trial, pick_cut;
		bit early;
		n = active_n;
		cut = 0;
		for (int i = 0; i < n; i++)
			for (int j = i + 1; j < n; j++)
				if (split[i] != split[j]) cut += wt(i, j);
		best = cut;
		moves = 0;
		early = 0;
		for (int pass = 0; pass <= n; pass++) begin
			mark_moves(n);
			pick = n;
			pick_cut = 0;
			for (int v = 0; v < n; v++) begin
				if (!can_move[v]) continue;
				trial = cut_after_flip(cut, v, n);
				split[v] ^= 1'b1;
				if (trial > pick_cut && sides_connected(n)) begin
					pick_cut = trial;
					pick = v;
				end
				split[v] ^= 1'b1;
			end
			if (pick == n) begin
				early = 1;
				break;
			end
			cut = cut_after_flip(cut, pick, n);
			split[pick] ^= 1'b1;
			if (cut > best) best = cut;
			if (moves < 255) moves++;
		end
		r.final_cut = clip30(cut);
		r.best_cut = clip30(best);
		r.passes_done = 8'(moves);
		r.stopped_early = early;
		r.vertex_side = 0;
		return r;
	endfunction

	function automatic void apply_request(logic [1:0] k, int a, int b, logic [15:0] w,
			bit sd);
		answer_t r;
		bit a_ok;
		a_ok = a >= 1 && a <= NV;
		case (k)
			cmcls_pkg::KIND_EDGE: begin
				if (a_ok && b >= 1 && b <= NV && a != b) begin
					graph_w[(a-1)*NV + (b-1)] = w;
					graph_w[(b-1)*NV + (a-1)] = w;
				end
			end
			cmcls_pkg::KIND_SIDE: begin
				if (a_ok) split[a-1] = sd;
			end
			cmcls_pkg::KIND_QUERY: begin
				r.final_cut = 0;
				r.best_cut = 0;
				r.passes_done = 0;
				r.stopped_early = 0;
				r.vertex_side = a_ok ? split[a-1] : 1'b0;
				queue_answer(r);
				queries++;
			end
			default: begin
				queue_answer(search_cut());
				searches++;
			end
		endcase
	endfunction

	task automatic send_request(logic [1:0] k, int a, int b, logic [15:0] w, bit sd);
		if ($urandom_range(99) < idle_pct) begin
			start = 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start = 1;
		kind = k;
		vertex_a = 8'(a);
		vertex_b = 8'(b);
		weight = w;
		side = sd;
		do @(posedge clk); while (busy);
		apply_request(k, a, b, w, sd);
		requests_sent++;
		@(negedge clk);
		start = 0;
	endtask

	task automatic wait_drained();
		while (pending_answers.size() != 0) @(negedge clk);
		// an edge load may still be finishing its second write
		repeat (4) @(negedge clk);
	endtask

	task automatic write_vertex_count(logic [7:0] value);
		wait_drained();
		cfg_valid = 1;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		active_n = (value < 2) ? 2 : ((value > NV) ? NV : int'(value));
		@(negedge clk);
		cfg_valid = 0;
	endtask

	// check each answer against the oldest prediction
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			answers_seen++;
			if (pending_answers.size() == 0) begin
				$error("unexpected answer, final_cut %0d", final_cut);
				errors++;
			end else begin
				e = pending_answers.pop_front();
				if (final_cut !== e.final_cut) begin
					$error("final_cut: expected %0d, got %0d", e.final_cut, final_cut);
					errors++;
				end
				if (best_cut !== e.best_cut) begin
					$error("best_cut: expected %0d, got %0d", e.best_cut, best_cut);
					errors++;
				end
				if (passes_done !== e.passes_done) begin
					$error("passes_done: expected %0d, got %0d", e.passes_done, passes_done);
					errors++;
				end
				if (stopped_early !== e.stopped_early) begin
					$error("stopped_early: expected %0d, got %0d", e.stopped_early,
						stopped_early);
					errors++;
				end
				if (vertex_side !== e.vertex_side) begin
					$error("vertex_side: expected %0d, got %0d", e.vertex_side, vertex_side);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("connected_max_cut_local_search_test: errors");
			$finish;
		end
	end

	// extremes, ignored loads, a full-size search and the count clamps
	task automatic test_directed();
		send_request(cmcls_pkg::KIND_EDGE, 1, 128, 16'hFFFF, 0);
		send_request(cmcls_pkg::KIND_EDGE, 1, 2, 16'hFFFF, 0);
		send_request(cmcls_pkg::KIND_EDGE, 1, 3, 16'd1, 0);
		send_request(cmcls_pkg::KIND_EDGE, 5, 5, 16'd77, 0);
		send_request(cmcls_pkg::KIND_EDGE, 0, 4, 16'd9, 1);
		send_request(cmcls_pkg::KIND_EDGE, 255, 129, 16'h5AA5, 1);
		send_request(cmcls_pkg::KIND_SIDE, 128, 0, 0, 1);
		send_request(cmcls_pkg::KIND_SIDE, 2, 0, 0, 1);
		send_request(cmcls_pkg::KIND_SIDE, 0, 0, 0, 1);
		send_request(cmcls_pkg::KIND_SIDE, 200, 0, 0, 1);
		send_request(cmcls_pkg::KIND_QUERY, 128, 0, 0, 0);
		send_request(cmcls_pkg::KIND_QUERY, 0, 0, 0, 0);
		send_request(cmcls_pkg::KIND_QUERY, 255, 0, 0, 0);
		send_request(cmcls_pkg::KIND_RUN, 0, 0, 0, 0);
		write_vertex_count(8'd0);
		send_request(cmcls_pkg::KIND_RUN, 0, 0, 0, 0);
		write_vertex_count(8'd255);
		send_request(cmcls_pkg::KIND_QUERY, 1, 0, 0, 0);
		write_vertex_count(8'd4);
		// lone vertex on one side: flipping it would empty that side
		send_request(cmcls_pkg::KIND_EDGE, 2, 3, 16'd5, 0);
		send_request(cmcls_pkg::KIND_EDGE, 2, 4, 16'd6, 0);
		send_request(cmcls_pkg::KIND_EDGE, 1, 4, 16'd7, 0);
		send_request(cmcls_pkg::KIND_SIDE, 1, 0, 0, 0);
		send_request(cmcls_pkg::KIND_SIDE, 3, 0, 0, 0);
		send_request(cmcls_pkg::KIND_SIDE, 4, 0, 0, 0);
		send_request(cmcls_pkg::KIND_RUN, 0, 0, 0, 0);
		send_request(cmcls_pkg::KIND_QUERY, 2, 0, 0, 0);
	endtask

	task automatic test_random_searches(int pct, int item_goal);
		int n, goal, ne;
		idle_pct = pct;
		goal = requests_sent + item_goal;
		while (requests_sent < goal) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(2, 3) : $urandom_range(4, 10);
			write_vertex_count(8'(n));
			ne = $urandom_range(5, 25);
			for (int e = 0; e < ne; e++) begin
				if ($urandom_range(9) == 0)
					send_request(cmcls_pkg::KIND_EDGE, $urandom_range(255), $urandom_range(255),
						16'($urandom_range(65535)), 1'($urandom));
				else
					send_request(cmcls_pkg::KIND_EDGE, $urandom_range(1, n), $urandom_range(1, n),
						($urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(65535)),
						1'($urandom));
			end
			for (int v = 1; v <= n; v++)
				if ($urandom_range(3) != 0) send_request(cmcls_pkg::KIND_SIDE, v,
					$urandom_range(255), 16'($urandom_range(65535)), 1'($urandom));
			if ($urandom_range(3) == 0)
				send_request(cmcls_pkg::KIND_SIDE, $urandom_range(129, 255), 0, 0, 1'($urandom));
			send_request(cmcls_pkg::KIND_RUN, $urandom_range(255), $urandom_range(255),
				16'($urandom_range(65535)), 1'($urandom));
			repeat ($urandom_range(1, 4))
				send_request(cmcls_pkg::KIND_QUERY, ($urandom_range(7) == 0)
					? $urandom_range(255) : $urandom_range(1, n), 0, 0, 0);
			if ($urandom_range(4) == 0) wait_drained();
		end
	endtask

	initial begin
		for (int i = 0; i < NV*NV; i++) graph_w[i] = 0;
		for (int i = 0; i < NV; i++) split[i] = 0;
		active_n = cmcls_pkg::VC_RESET;
		repeat (10) @(negedge clk);
		arst_n = 1;
		test_directed();
		test_random_searches(6, 630);
		test_random_searches(52, 630);
		test_random_searches(0, 640);
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (50) @(negedge clk);
		$display("covered %0d requests: %0d searches and %0d side queries, %0d answers",
			requests_sent, searches, queries, answers_seen);
		$display("vertex counts from the clamped low end to the full graph size");
		if (errors == 0)
			$display("connected_max_cut_local_search_test: clean");
		else
			$display("connected_max_cut_local_search_test: errors");
		$finish;
	end

endmodule
